// ===== rtl/i2a_pkg.sv =====
// ============================================================================
// i2a_pkg: shared definitions for the integer-to-ASCII formatter
// Opcodes, field layout, ASCII codes, digit-generator constants and the
// structs that pass between the digit generator and the character emitter.
// ============================================================================
`timescale 1ns / 1ps

package i2a_pkg;

    // Conversion opcodes; codes above OP_HEXU are not conversions.
    localparam logic [2:0] OP_SDEC = 3'd0;
    localparam logic [2:0] OP_UDEC = 3'd1;
    localparam logic [2:0] OP_OCT  = 3'd2;
    localparam logic [2:0] OP_HEXL = 3'd3;
    localparam logic [2:0] OP_HEXU = 3'd4;

    localparam int OPCODE_W   = 3;
    localparam int VALUE_W    = 64;
    localparam int WIDTH_W    = 7;
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 8;
    localparam int MAX_WIDTH  = 64;

    // Bit positions of the fields inside s_tdata.
    localparam int TD_NARROW  = 64;
    localparam int TD_WIDTH_LO = 65;
    localparam int TD_LEFT    = 72;
    localparam int TD_PLUS    = 73;
    localparam int TD_SPACE   = 74;
    localparam int TD_ZERO    = 75;

    // Digit register: enough nibble slots for 22 octal digits of a 64-bit value.
    localparam int NUM_DIGITS  = 24;
    localparam int DIG_BITS    = NUM_DIGITS * 4;
    localparam int DIG_CNT_W   = $clog2(NUM_DIGITS + 1);
    localparam int OCT_DIGITS  = (VALUE_W + 2) / 3;
    localparam int HEX_DIGITS  = VALUE_W / 4;
    localparam int BIN_CNT_W   = $clog2(VALUE_W);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    typedef enum logic [1:0] {
        BASE_DEC,
        BASE_OCT,
        BASE_HEX
    } base_t;

    // Handshake from the emitter to the digit generator.
    typedef struct packed {
        logic shift;    // consume the leading digit
        logic free;     // conversion fully emitted, return to idle
    } dg_step_t;

    // Status from the digit generator to the emitter.
    typedef struct packed {
        logic                 done;
        logic [DIG_CNT_W-1:0] nd;
        logic [3:0]           digit;
    } dg_stat_t;

    // Formatting job latched by the emitter when a conversion starts.
    typedef struct packed {
        logic               sign_en;
        logic [7:0]         sign_char;
        logic [WIDTH_W-1:0] width;
        logic               left;
        logic               zero;
        logic               upper;
    } em_job_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base_char;
        begin
            base_char = upper ? CH_UPPER_A : CH_LOWER_A;
            if (d < 4'd10) begin
                digit_char = CH_ZERO + {4'b0000, d};
            end else begin
                digit_char = base_char + {4'b0000, d} - 8'd10;
            end
        end
    endfunction

endpackage

// ===== rtl/i2a_digit_gen.sv =====
// ============================================================================
// i2a_digit_gen: digit generator
// Turns a 64-bit magnitude into base 10, 8 or 16 digits in a nibble shift
// register, strips leading zeros, then hands the digits out top first.
// ============================================================================
`timescale 1ns / 1ps

module i2a_digit_gen (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  i2a_pkg::base_t          base,
    input  logic [i2a_pkg::VALUE_W-1:0] mag,
    input  i2a_pkg::dg_step_t       step,
    output i2a_pkg::dg_stat_t       stat
);
    import i2a_pkg::*;

    typedef enum logic [1:0] {
        G_IDLE,
        G_CONV,
        G_STRIP,
        G_HOLD
    } gen_state_t;

    gen_state_t           state_reg, state_next;
    logic [VALUE_W-1:0]   bin_reg, bin_next;
    logic [DIG_BITS-1:0]  dig_reg, dig_next;
    logic [BIN_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIG_CNT_W-1:0] nd_reg, nd_next;

    logic [DIG_BITS-1:0]  adj;
    logic [DIG_BITS-1:0]  oct_load;
    logic [DIG_BITS-1:0]  hex_load;
    logic [VALUE_W+1:0]   mag_ext;
    logic [3:0]           top_digit;

    assign top_digit = dig_reg[DIG_BITS-1 -: 4];
    assign mag_ext   = {2'b00, mag};

    // Double-dabble correction: each BCD digit of five or more gets plus three.
    always_comb begin
        for (int k = 0; k < NUM_DIGITS; k++) begin
            adj[4*k +: 4] = (dig_reg[4*k +: 4] >= 4'd5) ? (dig_reg[4*k +: 4] + 4'd3)
                                                         : dig_reg[4*k +: 4];
        end
    end

    always_comb begin
        oct_load = '0;
        hex_load = '0;
        for (int k = 0; k < OCT_DIGITS; k++) begin
            oct_load[4*k +: 4] = {1'b0, mag_ext[3*k +: 3]};
        end
        for (int k = 0; k < HEX_DIGITS; k++) begin
            hex_load[4*k +: 4] = mag[4*k +: 4];
        end
    end

    always_comb begin
        state_next = state_reg;
        bin_next   = bin_reg;
        dig_next   = dig_reg;
        cnt_next   = cnt_reg;
        nd_next    = nd_reg;
        case (state_reg)
            G_IDLE: begin
                if (start) begin
                    nd_next = DIG_CNT_W'(NUM_DIGITS);
                    case (base)
                        BASE_DEC: begin
                            bin_next   = mag;
                            dig_next   = '0;
                            cnt_next   = BIN_CNT_W'(VALUE_W - 1);
                            state_next = G_CONV;
                        end
                        BASE_OCT: begin
                            dig_next   = oct_load;
                            state_next = G_STRIP;
                        end
                        default: begin
                            dig_next   = hex_load;
                            state_next = G_STRIP;
                        end
                    endcase
                end
            end
            G_CONV: begin
                dig_next = {adj[DIG_BITS-2:0], bin_reg[VALUE_W-1]};
                bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = G_STRIP;
                end
            end
            G_STRIP: begin
                // One leading zero per cycle; the last digit always stays.
                if (top_digit == 4'd0 && nd_reg > DIG_CNT_W'(1)) begin
                    dig_next = {dig_reg[DIG_BITS-5:0], 4'd0};
                    nd_next  = nd_reg - 1'b1;
                end else begin
                    state_next = G_HOLD;
                end
            end
            G_HOLD: begin
                if (step.shift) begin
                    dig_next = {dig_reg[DIG_BITS-5:0], 4'd0};
                end
                if (step.free) begin
                    state_next = G_IDLE;
                end
            end
            default: begin
                state_next = G_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= G_IDLE;
        end else begin
            state_reg <= state_next;
        end
        bin_reg <= bin_next;
        dig_reg <= dig_next;
        cnt_reg <= cnt_next;
        nd_reg  <= nd_next;
    end

    assign stat.done  = (state_reg == G_HOLD);
    assign stat.nd    = nd_reg;
    assign stat.digit = top_digit;

endmodule

// ===== rtl/i2a_emitter.sv =====
// ============================================================================
// i2a_emitter: character emitter
// Sequences leading spaces, sign, zero padding, digits and trailing spaces
// into a registered output stage, one character per transfer.
// ============================================================================
`timescale 1ns / 1ps

module i2a_emitter (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  i2a_pkg::em_job_t                  job,
    input  i2a_pkg::dg_stat_t                 dg_stat,
    output i2a_pkg::dg_step_t                 dg_step,
    output logic                              idle,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [i2a_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tlast
);
    import i2a_pkg::*;

    typedef enum logic [2:0] {
        E_IDLE,
        E_WAIT,
        E_PRE,
        E_SIGN,
        E_ZERO,
        E_DIG,
        E_POST
    } em_state_t;

    em_state_t            state_reg, state_next;
    em_job_t              job_reg, job_next;
    logic [WIDTH_W-1:0]   pad_reg, pad_next;
    logic [DIG_CNT_W-1:0] dcnt_reg, dcnt_next;
    logic                 tvalid_reg, tvalid_next;
    logic [7:0]           char_reg, char_next;
    logic                 last_reg, last_next;

    logic                 out_free;
    logic                 emit;
    logic                 emit_last;
    logic [7:0]           emit_char;
    logic [WIDTH_W-1:0]   text_len;
    logic [WIDTH_W-1:0]   pad_calc;

    assign out_free = !tvalid_reg || m_tready;
    assign text_len = WIDTH_W'(dg_stat.nd) + WIDTH_W'(job_reg.sign_en);
    assign pad_calc = (job_reg.width > text_len) ? (job_reg.width - text_len) : '0;

    always_comb begin
        state_next    = state_reg;
        job_next      = job_reg;
        pad_next      = pad_reg;
        dcnt_next     = dcnt_reg;
        emit          = 1'b0;
        emit_last     = 1'b0;
        emit_char     = CH_SPACE;
        dg_step.shift = 1'b0;
        dg_step.free  = 1'b0;
        case (state_reg)
            E_IDLE: begin
                if (start) begin
                    job_next   = job;
                    state_next = E_WAIT;
                end
            end
            E_WAIT: begin
                if (dg_stat.done) begin
                    pad_next  = pad_calc;
                    dcnt_next = dg_stat.nd;
                    if (!job_reg.left && !job_reg.zero && pad_calc != '0) begin
                        state_next = E_PRE;
                    end else if (job_reg.sign_en) begin
                        state_next = E_SIGN;
                    end else if (!job_reg.left && job_reg.zero && pad_calc != '0) begin
                        state_next = E_ZERO;
                    end else begin
                        state_next = E_DIG;
                    end
                end
            end
            E_PRE: begin
                if (out_free) begin
                    emit     = 1'b1;
                    pad_next = pad_reg - 1'b1;
                    if (pad_reg == WIDTH_W'(1)) begin
                        state_next = job_reg.sign_en ? E_SIGN : E_DIG;
                    end
                end
            end
            E_SIGN: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_char = job_reg.sign_char;
                    if (!job_reg.left && job_reg.zero && pad_reg != '0) begin
                        state_next = E_ZERO;
                    end else begin
                        state_next = E_DIG;
                    end
                end
            end
            E_ZERO: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_char = CH_ZERO;
                    pad_next  = pad_reg - 1'b1;
                    if (pad_reg == WIDTH_W'(1)) begin
                        state_next = E_DIG;
                    end
                end
            end
            E_DIG: begin
                if (out_free) begin
                    emit          = 1'b1;
                    emit_char     = digit_char(dg_stat.digit, job_reg.upper);
                    dg_step.shift = 1'b1;
                    dcnt_next     = dcnt_reg - 1'b1;
                    if (dcnt_reg == DIG_CNT_W'(1)) begin
                        if (job_reg.left && pad_reg != '0) begin
                            state_next = E_POST;
                        end else begin
                            emit_last    = 1'b1;
                            dg_step.free = 1'b1;
                            state_next   = E_IDLE;
                        end
                    end
                end
            end
            E_POST: begin
                if (out_free) begin
                    emit     = 1'b1;
                    pad_next = pad_reg - 1'b1;
                    if (pad_reg == WIDTH_W'(1)) begin
                        emit_last    = 1'b1;
                        dg_step.free = 1'b1;
                        state_next   = E_IDLE;
                    end
                end
            end
            default: begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_comb begin
        tvalid_next = tvalid_reg && !m_tready;
        char_next   = char_reg;
        last_next   = last_reg;
        if (emit) begin
            tvalid_next = 1'b1;
            char_next   = emit_char;
            last_next   = emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= E_IDLE;
            tvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            tvalid_reg <= tvalid_next;
        end
        job_reg  <= job_next;
        pad_reg  <= pad_next;
        dcnt_reg <= dcnt_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign idle     = (state_reg == E_IDLE);
    assign m_tvalid = tvalid_reg;
    assign m_tdata  = char_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== rtl/integer_to_ascii_formatter.sv =====
// ============================================================================
// integer_to_ascii_formatter: printf-style integer conversion with padding
// Accepts one conversion request per transfer and streams out the ASCII
// characters of the padded field, marking the final one with tlast.
// ============================================================================
`timescale 1ns / 1ps

// One request is in flight at a time. After the request transfer, decimal
// conversions run through a bit-serial binary-to-BCD shift register
// (one operand bit per cycle), octal and hex load their digits directly, and
// all bases then drop leading zeros, at most 23, at one digit per cycle.
// The field then leaves at one character per cycle unless the output stalls,
// max(width, text length) characters, where the text length is the digit
// count plus one for a sign.
// The block raises s_tready in the cycle after the final character of the
// current request has been loaded into the output register. Requests with an
// opcode of 5 to 7 are taken and produce no characters.

module integer_to_ascii_formatter (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Request channel.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata, from bit 0 up: value_bits[63:0], narrow_operand, field_width[6:0],
    // left_justify, force_plus, space_sign, zero_pad, four zero bits.
    input  logic [i2a_pkg::S_TDATA_W-1:0]     s_tdata,
    // s_tuser, from bit 0 up: opcode[2:0].
    input  logic [i2a_pkg::OPCODE_W-1:0]      s_tuser,
    // Character channel.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata, from bit 0 up: character[7:0]. m_tlast carries last_char.
    output logic [i2a_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tlast
);
    import i2a_pkg::*;

    logic               in_xfer;
    logic               op_valid;
    logic               conv_start;
    logic [VALUE_W-1:0] val_raw;
    logic [VALUE_W-1:0] val_ext;
    logic [VALUE_W-1:0] mag;
    logic               negative;
    logic [WIDTH_W-1:0] width_in;
    base_t              base;
    em_job_t            job;
    dg_stat_t           dg_stat;
    dg_step_t           dg_step;
    logic               em_idle;

    assign in_xfer    = s_tvalid && s_tready;
    assign op_valid   = (s_tuser <= OP_HEXU);
    assign conv_start = in_xfer && op_valid;
    assign s_tready   = em_idle;

    // Operand preparation: narrow operands are sign-extended for signed
    // decimal and zero-extended otherwise; negative values become magnitudes.
    assign val_raw = s_tdata[VALUE_W-1:0];

    always_comb begin
        if (s_tdata[TD_NARROW]) begin
            if (s_tuser == OP_SDEC) begin
                val_ext = {{(VALUE_W/2){val_raw[VALUE_W/2-1]}}, val_raw[VALUE_W/2-1:0]};
            end else begin
                val_ext = {{(VALUE_W/2){1'b0}}, val_raw[VALUE_W/2-1:0]};
            end
        end else begin
            val_ext = val_raw;
        end
    end

    assign negative = (s_tuser == OP_SDEC) && val_ext[VALUE_W-1];
    assign mag      = negative ? (~val_ext + 1'b1) : val_ext;

    always_comb begin
        case (s_tuser)
            OP_SDEC, OP_UDEC: base = BASE_DEC;
            OP_OCT:           base = BASE_OCT;
            default:          base = BASE_HEX;
        endcase
    end

    // Widths beyond the field limit are clamped.
    assign width_in = (s_tdata[TD_WIDTH_LO +: WIDTH_W] > WIDTH_W'(MAX_WIDTH))
                    ? WIDTH_W'(MAX_WIDTH) : s_tdata[TD_WIDTH_LO +: WIDTH_W];

    // Sign selection applies to signed decimal only; '+' wins over ' '.
    always_comb begin
        job.sign_en   = 1'b0;
        job.sign_char = CH_SPACE;
        if (s_tuser == OP_SDEC) begin
            if (negative) begin
                job.sign_en   = 1'b1;
                job.sign_char = CH_MINUS;
            end else if (s_tdata[TD_PLUS]) begin
                job.sign_en   = 1'b1;
                job.sign_char = CH_PLUS;
            end else if (s_tdata[TD_SPACE]) begin
                job.sign_en   = 1'b1;
                job.sign_char = CH_SPACE;
            end
        end
        job.width = width_in;
        job.left  = s_tdata[TD_LEFT];
        // With left justification the zero flag is ignored: spaces go right.
        job.zero  = s_tdata[TD_ZERO] && !s_tdata[TD_LEFT];
        job.upper = (s_tuser == OP_HEXU);
    end

    i2a_digit_gen u_digit_gen (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (conv_start),
        .base    (base),
        .mag     (mag),
        .step    (dg_step),
        .stat    (dg_stat)
    );

    i2a_emitter u_emitter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (conv_start),
        .job      (job),
        .dg_stat  (dg_stat),
        .dg_step  (dg_step),
        .idle     (em_idle),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== rtl/i2a_checker.sv =====
// ============================================================================
// i2a_checker: port-level checks for the integer-to-ASCII formatter
// Watches the request and character channels and flags behavior that the
// formatter must never show.
// ============================================================================
`timescale 1ns / 1ps

module i2a_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [i2a_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [i2a_pkg::OPCODE_W-1:0]      s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [i2a_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              m_tlast
);
    import i2a_pkg::*;

    // A character held back by the sink stays put until it is transferred.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("character changed while stalled");

    // Every character of a field (a space, a sign, a digit or a hex letter) lies between a space and 'z'.
    a_printable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata >= CH_SPACE) && (m_tdata <= 8'h7A))
        else $error("non-printable character emitted");

    // While a field is only partly out, no new request is taken.
    a_busy_mid_field: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("request accepted in the middle of a field");

    // A valid conversion request makes the block busy on the next cycle.
    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser <= OP_HEXU) |=> !s_tready)
        else $error("still ready right after a conversion request");

endmodule

bind integer_to_ascii_formatter i2a_checker u_i2a_checker (.*);

// ===== verif/testbench.sv =====
// ============================================================================
// testbench: self-checking bench for integer_to_ascii_formatter
// Sends integer conversion requests on the request stream and predicts the
// padded ASCII field for each one. Every character transfer on the output
// stream is checked against the oldest predicted character. The run covers
// directed corner cases, random traffic with gaps and stalls on both sides,
// a long output hold-off, and a back-to-back stretch with no idling at all.
// ============================================================================
`timescale 1ns / 1ps

module testbench;

    import i2a_pkg::*;

    // The request fields allow three more codes above the last conversion.
    localparam logic [2:0] OP_LAST_CODE = 3'd7;

    // Slowest request is a decimal one: binary-to-BCD work, leading-zero
    // removal, then up to 64 characters.
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 1_000_000;

    localparam int RANDOM_ITEMS = 400;
    localparam int HOLD_ITEMS   = 20;
    localparam int STREAM_ITEMS = 60;
    localparam int HOLD_CYCLES  = 400;

    // One conversion request, field by field.
    typedef struct {
        logic [2:0]  opcode;
        logic [63:0] value;
        logic        narrow;
        logic [6:0]  width;
        logic        left;
        logic        plus;
        logic        space;
        logic        zero;
    } conv_req_t;

    // One predicted character of a formatted field.
    typedef struct {
        logic [7:0] ch;
        logic       last;
    } field_char_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // s_tdata, from bit 0 up: value_bits[63:0], narrow_operand, field_width[6:0],
    // left_justify, force_plus, space_sign, zero_pad, four zero bits.
    logic [79:0] s_tdata;
    // s_tuser, from bit 0 up: opcode[2:0].
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // m_tdata, from bit 0 up: character[7:0]. m_tlast carries last_char.
    logic [7:0]  m_tdata;
    logic        m_tlast;

    // Characters still owed by the block, oldest first.
    field_char_t field_chars_q[$];

    int mismatches     = 0;
    int requests_sent  = 0;
    int requests_void  = 0;
    int chars_checked  = 0;
    int fields_closed  = 0;
    int cycle_count    = 0;

    // Sender pacing: bursts of back-to-back transfers with gaps between them.
    bit tx_idle_en    = 1'b0;
    int tx_burst_left = 0;

    // Receiver pacing: alternating ready and stall runs, or a long hold-off.
    bit rx_stall_en    = 1'b0;
    int rx_hold_cycles = 0;
    bit rx_ready_phase = 1'b1;
    int rx_phase_left  = 0;

    integer_to_ascii_formatter u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Hard stop in case the block hangs or loses a character.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d characters outstanding.",
                     cycle_count, field_chars_q.size());
            $display("integer_to_ascii_formatter verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [7:0] expected,
                                   input logic [7:0] actual);
        $display("[%0t] MISMATCH %s: expected 'h%02h, got 'h%02h (character %0d)",
                 $realtime, what, expected, actual, chars_checked);
        mismatches++;
    endtask

    // Builds the padded field for one request and appends it to the queue of
    // owed characters. Unused opcodes owe nothing.
    function automatic void format_field(input conv_req_t req);
        logic [63:0] operand;
        logic [63:0] magnitude;
        logic [63:0] radix;
        logic [7:0]  sign_ch;
        logic        has_sign;
        string       digit_set;
        logic [7:0]  digits[$];
        logic [7:0]  text[$];
        int          width_sat;
        int          text_len;
        int          pad;
        field_char_t fc;

        operand   = req.value;
        has_sign  = 1'b0;
        sign_ch   = CH_SPACE;
        digit_set = "0123456789abcdef";
        case (req.opcode)
            OP_SDEC: begin
                if (req.narrow) operand = {{32{operand[31]}}, operand[31:0]};
                if (operand[63]) begin
                    // The most negative value negates to itself, which read
                    // as unsigned is exactly its magnitude.
                    magnitude = ~operand + 64'd1;
                    has_sign  = 1'b1;
                    sign_ch   = CH_MINUS;
                end else begin
                    magnitude = operand;
                    has_sign  = req.plus || req.space;
                    sign_ch   = req.plus ? CH_PLUS : CH_SPACE;
                end
                radix = 64'd10;
            end
            OP_UDEC, OP_OCT, OP_HEXL, OP_HEXU: begin
                // Sign flags have no effect on the unsigned conversions.
                if (req.narrow) operand = {32'd0, operand[31:0]};
                magnitude = operand;
                radix = (req.opcode == OP_UDEC) ? 64'd10 :
                        (req.opcode == OP_OCT)  ? 64'd8  : 64'd16;
                if (req.opcode == OP_HEXU) digit_set = "0123456789ABCDEF";
            end
            default: return;
        endcase

        // Least significant digit first; zero still yields one digit.
        do begin
            digits.push_back(digit_set[int'(magnitude % radix)]);
            magnitude = magnitude / radix;
        end while (magnitude != 64'd0);

        width_sat = (req.width > MAX_WIDTH) ? MAX_WIDTH : int'(req.width);
        text_len  = digits.size() + (has_sign ? 1 : 0);
        pad       = (width_sat > text_len) ? width_sat - text_len : 0;

        // Left justification wins over zero padding: spaces go on the right.
        if (!req.left && !req.zero) repeat (pad) text.push_back(CH_SPACE);
        if (has_sign) text.push_back(sign_ch);
        if (!req.left && req.zero) repeat (pad) text.push_back(CH_ZERO);
        for (int i = digits.size() - 1; i >= 0; i--) text.push_back(digits[i]);
        if (req.left) repeat (pad) text.push_back(CH_SPACE);

        foreach (text[i]) begin
            fc.ch   = text[i];
            fc.last = (i == text.size() - 1);
            field_chars_q.push_back(fc);
        end
    endfunction

    // Every character transfer is held against the oldest owed character.
    always @(posedge aclk) begin
        field_char_t exp_char;
        if (aresetn && m_tvalid && m_tready) begin
            if (field_chars_q.size() == 0) begin
                report_mismatch("character with none owed", 8'h00, m_tdata);
            end else begin
                exp_char = field_chars_q.pop_front();
                if (m_tdata !== exp_char.ch)
                    report_mismatch("character", exp_char.ch, m_tdata);
                if (m_tlast !== exp_char.last)
                    report_mismatch("last marker", {7'd0, exp_char.last}, {7'd0, m_tlast});
                if (exp_char.last) fields_closed++;
            end
            chars_checked++;
        end
    end

    // The receiver either holds off for a counted stretch, stays ready, or
    // alternates ready and stall runs of random length.
    always @(negedge aclk) begin
        if (rx_hold_cycles > 0) begin
            m_tready = 1'b0;
            rx_hold_cycles--;
        end else if (!rx_stall_en) begin
            m_tready = 1'b1;
        end else begin
            if (rx_phase_left == 0) begin
                rx_ready_phase = !rx_ready_phase;
                rx_phase_left  = rx_ready_phase ? $urandom_range(1, 12) : $urandom_range(1, 5);
            end
            m_tready = rx_ready_phase;
            rx_phase_left--;
        end
    end

    // Offers one request and returns once it has been transferred.
    task automatic send_request(input conv_req_t req);
        @(negedge aclk);
        if (tx_idle_en && tx_burst_left == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            tx_burst_left = $urandom_range(1, 8);
        end
        s_tdata  = {4'b0000, req.zero, req.space, req.plus, req.left,
                    req.width, req.narrow, req.value};
        s_tuser  = req.opcode;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (tx_burst_left > 0) tx_burst_left--;
        requests_sent++;
        if (req.opcode > OP_HEXU) requests_void++;
        format_field(req);
    endtask

    // Drops the request valid, waits for every owed character, then gives an
    // unused-opcode request time to pass through.
    task automatic wait_quiet();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (field_chars_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic conv_req_t make_req(input logic [2:0] opcode, input logic [63:0] value,
                                           input logic narrow, input logic [6:0] width,
                                           input logic left, input logic plus,
                                           input logic space, input logic zero);
        conv_req_t req;
        req.opcode = opcode;
        req.value  = value;
        req.narrow = narrow;
        req.width  = width;
        req.left   = left;
        req.plus   = plus;
        req.space  = space;
        req.zero   = zero;
        return req;
    endfunction

    // Random request; widths stay mostly small to keep fields short.
    function automatic conv_req_t random_request();
        conv_req_t req;
        int        shift;
        req.opcode = ($urandom_range(0, 19) == 0) ?
                     3'($urandom_range(OP_HEXU + 1, OP_LAST_CODE)) :
                     3'($urandom_range(OP_SDEC, OP_HEXU));
        shift = $urandom_range(0, 63);
        case ($urandom_range(0, 5))
            0: req.value = {$urandom, $urandom};
            1: req.value = 64'($urandom_range(0, 99));
            2: req.value = -64'($urandom_range(1, 99));
            3: req.value = (64'd1 << shift) - 64'($urandom_range(0, 1));
            4: req.value = {$urandom, 1'b1, 31'($urandom)};
            default: begin
                case ($urandom_range(0, 3))
                    0: req.value = 64'd0;
                    1: req.value = {64{1'b1}};
                    2: req.value = {1'b1, 63'd0};
                    default: req.value = {1'b0, {63{1'b1}}};
                endcase
            end
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: req.width = 7'($urandom_range(0, 24));
            6, 7, 8:          req.width = 7'($urandom_range(0, MAX_WIDTH));
            default:          req.width = 7'($urandom_range(MAX_WIDTH + 1, 127));
        endcase
        req.narrow = 1'($urandom);
        req.left   = 1'($urandom);
        req.plus   = 1'($urandom);
        req.space  = 1'($urandom);
        req.zero   = 1'($urandom);
        return req;
    endfunction

    // Corner cases: extremes of the value and width, every conversion, the
    // sign flags, both padding styles and their conflict, unused opcodes.
    task automatic test_directed();
        tx_idle_en  = 1'b0;
        rx_stall_en = 1'b0;
        send_request(make_req(OP_SDEC, 64'd0,                   0, 7'd0,   0, 0, 0, 0));
        send_request(make_req(OP_SDEC, 64'h7FFF_FFFF_FFFF_FFFF, 0, 7'd0,   0, 1, 0, 0));
        // Most negative value, zero padded behind the minus sign.
        send_request(make_req(OP_SDEC, 64'h8000_0000_0000_0000, 0, 7'd30,  0, 0, 0, 1));
        send_request(make_req(OP_SDEC, {64{1'b1}},              0, 7'd4,   0, 0, 1, 0));
        send_request(make_req(OP_SDEC, 64'd42,                  0, 7'd8,   0, 0, 1, 0));
        // Narrow signed: bit 31 extends, the upper half is garbage.
        send_request(make_req(OP_SDEC, 64'hDEAD_BEEF_8000_0000, 1, 7'd12,  0, 0, 0, 1));
        send_request(make_req(OP_SDEC, 64'hFFFF_FFFF_7FFF_FFFF, 1, 7'd0,   0, 1, 1, 0));
        // Sign flags do nothing on unsigned, and the text overflows the width.
        send_request(make_req(OP_UDEC, {64{1'b1}},              0, 7'd5,   0, 1, 1, 0));
        send_request(make_req(OP_UDEC, {64{1'b1}},              1, 7'd16,  1, 0, 0, 0));
        send_request(make_req(OP_OCT,  {64{1'b1}},              0, 7'd0,   0, 0, 0, 0));
        // Width above the maximum saturates.
        send_request(make_req(OP_OCT,  64'd8,                   0, 7'd127, 0, 0, 0, 0));
        send_request(make_req(OP_HEXL, 64'hFEDC_BA98_7654_3210, 0, 7'd20,  0, 0, 0, 1));
        // Left and zero together: spaces on the right.
        send_request(make_req(OP_HEXU, 64'hFEDC_BA98_7654_3210, 0, 7'd20,  1, 0, 0, 1));
        send_request(make_req(OP_HEXU, 64'h1111_2222_ABCD_1234, 1, 7'd64,  1, 0, 0, 0));
        send_request(make_req(OP_SDEC, -64'd123,                0, 7'd10,  1, 1, 0, 1));
        send_request(make_req(OP_SDEC, 64'd5,                   0, 7'd64,  0, 1, 0, 1));
        send_request(make_req(OP_UDEC, 64'd0,                   0, 7'd1,   0, 0, 0, 0));
        send_request(make_req(OP_HEXL, 64'd0,                   0, 7'd3,   0, 0, 0, 1));
        for (int op = OP_HEXU + 1; op <= OP_LAST_CODE; op++)
            send_request(make_req(3'(op), {$urandom, $urandom}, 0, 7'd10, 0, 0, 0, 0));
        send_request(make_req(OP_SDEC, -64'd7,                  0, 7'd127, 0, 0, 0, 0));
        send_request(make_req(OP_OCT,  64'h0000_0000_FFFF_FFFF, 1, 7'd1,   0, 0, 0, 1));
        send_request(make_req(OP_UDEC, {64{1'b1}},              0, 7'd64,  0, 0, 0, 1));
        wait_quiet();
    endtask

    // Random requests with bursty sending and a stalling receiver.
    task automatic test_random_traffic();
        tx_idle_en    = 1'b1;
        tx_burst_left = 0;
        rx_stall_en   = 1'b1;
        repeat (RANDOM_ITEMS) send_request(random_request());
        wait_quiet();
    endtask

    // The receiver stops for a long stretch while requests keep coming, so
    // the block fills up and must hold off the request stream.
    task automatic test_output_hold_off();
        tx_idle_en  = 1'b0;
        rx_stall_en = 1'b1;
        @(posedge aclk);
        rx_hold_cycles = HOLD_CYCLES;
        repeat (HOLD_ITEMS) send_request(random_request());
        wait_quiet();
    endtask

    // Back-to-back requests with the receiver always ready.
    task automatic test_full_rate();
        tx_idle_en  = 1'b0;
        rx_stall_en = 1'b0;
        repeat (STREAM_ITEMS) send_request(random_request());
        wait_quiet();
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_SDEC;
        m_tready = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_random_traffic();
        test_output_hold_off();
        test_full_rate();

        $display("Sent %0d conversion requests (%0d with unused opcodes) in %0d cycles.",
                 requests_sent, requests_void, cycle_count);
        $display("Checked %0d characters across %0d formatted fields; %0d mismatches.",
                 chars_checked, fields_closed, mismatches);
        if (mismatches == 0) begin
            $display("integer_to_ascii_formatter verification clean");
        end else begin
            $display("integer_to_ascii_formatter verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/i2a_pkg.sv
rtl/i2a_digit_gen.sv
rtl/i2a_emitter.sv
rtl/integer_to_ascii_formatter.sv
rtl/i2a_checker.sv
verif/testbench.sv
